FILE: src/vfcm_pkg.sv
// ----------------------------------------------------------------------------
// vfcm_pkg
// Shared types and constants of the voxel face culling mesher.
// ----------------------------------------------------------------------------
package vfcm_pkg;

   // request modes
   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_MESH  = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_CHUNK_LINE   = 2'd0;
   localparam logic [1:0] CSR_CHUNK_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_VOXEL_SIZE   = 2'd2;

   // register reset values
   localparam logic [5:0] CHUNK_LINE_RESET   = 6'd16;
   localparam logic [7:0] CHUNK_HEIGHT_RESET = 8'd80;
   localparam logic [9:0] VOXEL_SIZE_RESET   = 10'd100;

   // face codes, in emission order
   localparam logic [2:0] FACE_POS_Z = 3'd0;
   localparam logic [2:0] FACE_NEG_Z = 3'd1;
   localparam logic [2:0] FACE_POS_Y = 3'd2;
   localparam logic [2:0] FACE_NEG_Y = 3'd3;
   localparam logic [2:0] FACE_POS_X = 3'd4;
   localparam logic [2:0] FACE_NEG_X = 3'd5;

   // values above this show every face
   localparam int SOLID_LIMIT = 20;
   localparam logic [21:0] VERTS_PER_FACE = 22'd4;

   // effective chunk extents, wide enough for the largest parameter values
   localparam int LINE_W   = 7;
   localparam int HEIGHT_W = 9;

   typedef enum logic [1:0] {
      OP_WRITE,
      OP_MESH,
      OP_CLEAR
   } cmd_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CENTER,
      ST_FACE,
      ST_FLUSH
   } back_state_type;

   typedef struct packed {
      logic [LINE_W-1:0]   line;
      logic [HEIGHT_W-1:0] height;
   } cfg_type;

   typedef struct packed {
      cmd_op_type  op;
      logic [4:0]  pos_x;
      logic [4:0]  pos_y;
      logic [6:0]  pos_z;
      logic [7:0]  value;
      logic [14:0] center_x;
      logic [14:0] center_y;
      logic [16:0] center_z;
   } cmd_type;

   typedef struct packed {
      logic [2:0]  face;
      logic [14:0] center_x;
      logic [14:0] center_y;
      logic [16:0] center_z;
      logic [21:0] first_vertex;
      logic        last;
   } rsp_type;

endpackage

FILE: src/voxel_face_cull_mesher_top.sv
// ----------------------------------------------------------------------------
// voxel_face_cull_mesher_top
// Voxel store with face culling: writes voxels and emits the visible faces
// of meshed voxels with scaled centers and running vertex indexes.
//
//   channel  ports                         handshake
//   req      mode pos_x pos_y pos_z value  push / full
//   rsp      face center_* first_vertex    pop / empty
//            last
//   csr      index data                    write, no wait
//
// The back end completes a write or clear request in its idle state; a meshed
// voxel goes through a center read, then one neighbor read and test per face on
// the single store port, and a flush step when the last face and an earlier one
// both show; an empty voxel ends after the center read.
// Reset clears the vertex count and both queues; the store holds no value
// until written.
// A full result queue holds the face sequencer; a full command queue raises
// req_full.
// ----------------------------------------------------------------------------
module voxel_face_cull_mesher_top #(
   parameter int MAX_LINE   = 32,
   parameter int MAX_HEIGHT = 128,
   parameter int VALUE_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [9:0]  csr_data,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_mode,
   input  logic [4:0]  req_pos_x,
   input  logic [4:0]  req_pos_y,
   input  logic [6:0]  req_pos_z,
   input  logic [7:0]  req_voxel_value,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [2:0]  rsp_face,
   output logic [14:0] rsp_center_x,
   output logic [14:0] rsp_center_y,
   output logic [16:0] rsp_center_z,
   output logic [21:0] rsp_first_vertex,
   output logic        rsp_last
);
   import vfcm_pkg::*;

   localparam int CMD_BITS = $bits(cmd_type);
   localparam int RSP_BITS = $bits(rsp_type);

   cfg_type             cfg;
   cmd_type             front_cmd, back_cmd;
   logic [CMD_BITS-1:0] cmd_q_data;
   logic                cmd_push, cmd_full, cmd_pop, cmd_empty;
   rsp_type             back_rsp, rsp_head;
   logic [RSP_BITS-1:0] rsp_q_data;
   logic                back_push, rsp_full;

   vfcm_front #(
      .MAX_LINE   (MAX_LINE),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_mode        (req_mode),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_pos_z       (req_pos_z),
      .req_voxel_value (req_voxel_value),
      .cfg             (cfg),
      .cmd_full        (cmd_full),
      .cmd_push        (cmd_push),
      .cmd             (front_cmd)
   );

   vfcm_queue #(
      .WIDTH (CMD_BITS),
      .DEPTH (2)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (CMD_BITS'(front_cmd)),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_q_data),
      .empty     (cmd_empty)
   );

   assign back_cmd = cmd_type'(cmd_q_data);

   vfcm_back #(
      .MAX_LINE   (MAX_LINE),
      .MAX_HEIGHT (MAX_HEIGHT),
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (back_cmd),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (back_push),
      .rsp_data  (back_rsp)
   );

   vfcm_queue #(
      .WIDTH (RSP_BITS),
      .DEPTH (2)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (back_push),
      .push_data (RSP_BITS'(back_rsp)),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_q_data),
      .empty     (rsp_empty)
   );

   assign rsp_head         = rsp_type'(rsp_q_data);
   assign rsp_face         = rsp_head.face;
   assign rsp_center_x     = rsp_head.center_x;
   assign rsp_center_y     = rsp_head.center_y;
   assign rsp_center_z     = rsp_head.center_z;
   assign rsp_first_vertex = rsp_head.first_vertex;
   assign rsp_last         = rsp_head.last;

endmodule

FILE: src/vfcm_queue.sv
// ----------------------------------------------------------------------------
// vfcm_queue
// Small first-in first-out queue of fixed-width words.
// ----------------------------------------------------------------------------
module vfcm_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    slot_mem [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full     = (count_ff == CNT_BITS'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: src/vfcm_front.sv
// ----------------------------------------------------------------------------
// vfcm_front
// Configuration registers, request classification and center scaling.
// ----------------------------------------------------------------------------
module vfcm_front #(
   parameter int MAX_LINE   = 32,
   parameter int MAX_HEIGHT = 128
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write,
   input  logic [1:0]       csr_index,
   input  logic [9:0]       csr_data,
   input  logic             req_push,
   output logic             req_full,
   input  logic [1:0]       req_mode,
   input  logic [4:0]       req_pos_x,
   input  logic [4:0]       req_pos_y,
   input  logic [6:0]       req_pos_z,
   input  logic [7:0]       req_voxel_value,
   output vfcm_pkg::cfg_type cfg,
   input  logic             cmd_full,
   output logic             cmd_push,
   output vfcm_pkg::cmd_type cmd
);
   import vfcm_pkg::*;

   logic [5:0] chunk_line_ff, chunk_line_in;
   logic [7:0] chunk_height_ff, chunk_height_in;
   logic [9:0] voxel_size_ff, voxel_size_in;
   logic       accept;
   logic       keep;
   logic       in_chunk;
   logic       addressable;

   always_comb begin
      chunk_line_in   = chunk_line_ff;
      chunk_height_in = chunk_height_ff;
      voxel_size_in   = voxel_size_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_CHUNK_LINE:   chunk_line_in   = csr_data[5:0];
            CSR_CHUNK_HEIGHT: chunk_height_in = csr_data[7:0];
            CSR_VOXEL_SIZE:   voxel_size_in   = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_line_ff   <= CHUNK_LINE_RESET;
         chunk_height_ff <= CHUNK_HEIGHT_RESET;
         voxel_size_ff   <= VOXEL_SIZE_RESET;
      end else begin
         chunk_line_ff   <= chunk_line_in;
         chunk_height_ff <= chunk_height_in;
         voxel_size_ff   <= voxel_size_in;
      end
   end

   // clamp the extents to what the store holds
   always_comb begin
      cfg.line   = (int'(chunk_line_ff) > MAX_LINE) ? LINE_W'(MAX_LINE)
                                                    : LINE_W'(chunk_line_ff);
      cfg.height = (int'(chunk_height_ff) > MAX_HEIGHT) ? HEIGHT_W'(MAX_HEIGHT)
                                                        : HEIGHT_W'(chunk_height_ff);
   end

   assign in_chunk    = (LINE_W'(req_pos_x) < cfg.line) && (LINE_W'(req_pos_y) < cfg.line)
                        && (HEIGHT_W'(req_pos_z) < cfg.height);
   assign addressable = (int'(req_pos_x) < MAX_LINE) && (int'(req_pos_y) < MAX_LINE)
                        && (int'(req_pos_z) < MAX_HEIGHT);

   always_comb begin
      keep         = 1'b0;
      cmd.op       = OP_WRITE;
      cmd.pos_x    = req_pos_x;
      cmd.pos_y    = req_pos_y;
      cmd.pos_z    = req_pos_z;
      cmd.value    = req_voxel_value;
      cmd.center_x = 15'(15'(req_pos_x) * 15'(voxel_size_ff));
      cmd.center_y = 15'(15'(req_pos_y) * 15'(voxel_size_ff));
      cmd.center_z = 17'(17'(req_pos_z) * 17'(voxel_size_ff));
      unique case (req_mode)
         MODE_WRITE: begin
            keep   = addressable;
            cmd.op = OP_WRITE;
         end
         MODE_MESH: begin
            keep   = in_chunk;
            cmd.op = OP_MESH;
         end
         MODE_CLEAR: begin
            keep   = 1'b1;
            cmd.op = OP_CLEAR;
         end
         default: keep = 1'b0;
      endcase
   end

   // drop requests that give no result and touch no state
   assign req_full = cmd_full;
   assign accept   = req_push && !cmd_full;
   assign cmd_push = accept && keep;

endmodule

FILE: src/vfcm_back.sv
// ----------------------------------------------------------------------------
// vfcm_back
// Voxel store and face sequencer: writes voxels, tests the six faces of a
// meshed voxel against its neighbors and emits one result per visible face.
// ----------------------------------------------------------------------------
module vfcm_back #(
   parameter int MAX_LINE   = 32,
   parameter int MAX_HEIGHT = 128,
   parameter int VALUE_BITS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  vfcm_pkg::cfg_type cfg,
   input  vfcm_pkg::cmd_type cmd,
   input  logic              cmd_empty,
   output logic              cmd_pop,
   input  logic              rsp_full,
   output logic              rsp_push,
   output vfcm_pkg::rsp_type rsp_data
);
   import vfcm_pkg::*;

   localparam int LINE_SQ     = MAX_LINE * MAX_LINE;
   localparam int STORE_DEPTH = LINE_SQ * MAX_HEIGHT;
   localparam int ADDR_BITS   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   logic [VALUE_BITS-1:0] store_mem [STORE_DEPTH];
   logic [VALUE_BITS-1:0] rd_data_ff;

   back_state_type        state_ff, state_in;
   cmd_type               cur_ff, cur_in;
   logic [ADDR_BITS-1:0]  addr_ff, addr_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic [2:0]            face_ff, face_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [2:0]            pend_face_ff, pend_face_in;
   logic [21:0]           pend_first_ff, pend_first_in;
   logic [21:0]           count_ff, count_in;

   logic                  mem_we, mem_re;
   logic [ADDR_BITS-1:0]  mem_addr;
   logic [VALUE_BITS-1:0] mem_wdata;
   logic                  solid, nb_empty, show, final_face, push_need, stall;

   function automatic logic [ADDR_BITS-1:0] addr_of(input logic [4:0] x,
                                                    input logic [4:0] y,
                                                    input logic [6:0] z);
      return ADDR_BITS'(x) + ADDR_BITS'(y) * ADDR_BITS'(MAX_LINE)
             + ADDR_BITS'(z) * ADDR_BITS'(LINE_SQ);
   endfunction

   // neighbor address; wraps where the neighbor is outside, then unused
   function automatic logic [ADDR_BITS-1:0] nb_addr(input logic [ADDR_BITS-1:0] base,
                                                    input logic [2:0] f);
      logic [ADDR_BITS-1:0] a;
      a = base;
      unique case (f)
         FACE_POS_Z: a = base + ADDR_BITS'(LINE_SQ);
         FACE_NEG_Z: a = base - ADDR_BITS'(LINE_SQ);
         FACE_POS_Y: a = base + ADDR_BITS'(MAX_LINE);
         FACE_NEG_Y: a = base - ADDR_BITS'(MAX_LINE);
         FACE_POS_X: a = base + 1'b1;
         FACE_NEG_X: a = base - 1'b1;
         default:    a = base;
      endcase
      return a;
   endfunction

   // visibility of the face under test; rd_data_ff holds its neighbor
   always_comb begin
      solid      = int'(value_ff) > SOLID_LIMIT;
      nb_empty   = (rd_data_ff == '0);
      final_face = (face_ff == FACE_NEG_X);
      case (face_ff)
         FACE_POS_Z: show = solid || (((HEIGHT_W'(cur_ff.pos_z) + 1'b1) < cfg.height)
                                      && nb_empty);
         FACE_NEG_Z: show = solid || ((cur_ff.pos_z != '0) && nb_empty);
         FACE_POS_Y: show = solid || ((LINE_W'(cur_ff.pos_y) + 1'b1) >= cfg.line)
                           || nb_empty;
         FACE_NEG_Y: show = solid || (cur_ff.pos_y == '0) || nb_empty;
         FACE_POS_X: show = solid || ((LINE_W'(cur_ff.pos_x) + 1'b1) >= cfg.line)
                           || nb_empty;
         FACE_NEG_X: show = solid || (cur_ff.pos_x == '0) || nb_empty;
         default:    show = 1'b0;
      endcase
      push_need = 1'b0;
      if (state_ff == ST_FACE) begin
         push_need = (pend_valid_ff && (show || final_face))
                     || (final_face && show && !pend_valid_ff);
      end else if (state_ff == ST_FLUSH) begin
         push_need = 1'b1;
      end
      stall = push_need && rsp_full;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty && cmd.op == OP_MESH) begin
               state_in = ST_CENTER;
            end
         end
         ST_CENTER: begin
            state_in = (rd_data_ff == '0) ? ST_IDLE : ST_FACE;
         end
         ST_FACE: begin
            if (!stall && final_face) begin
               state_in = (show && pend_valid_ff) ? ST_FLUSH : ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (!stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cur_in        = cur_ff;
      addr_in       = addr_ff;
      value_in      = value_ff;
      face_in       = face_ff;
      pend_valid_in = pend_valid_ff;
      pend_face_in  = pend_face_ff;
      pend_first_in = pend_first_ff;
      count_in      = count_ff;
      cmd_pop       = 1'b0;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_addr      = addr_of(cmd.pos_x, cmd.pos_y, cmd.pos_z);
      mem_wdata     = VALUE_BITS'(cmd.value);
      rsp_push      = 1'b0;
      rsp_data.face         = pend_face_ff;
      rsp_data.center_x     = cur_ff.center_x;
      rsp_data.center_y     = cur_ff.center_y;
      rsp_data.center_z     = cur_ff.center_z;
      rsp_data.first_vertex = pend_first_ff;
      rsp_data.last         = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               unique case (cmd.op)
                  OP_WRITE: mem_we = 1'b1;
                  OP_CLEAR: count_in = '0;
                  OP_MESH: begin
                     mem_re        = 1'b1;
                     cur_in        = cmd;
                     addr_in       = mem_addr;
                     face_in       = FACE_POS_Z;
                     pend_valid_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         ST_CENTER: begin
            value_in = rd_data_ff;
            mem_addr = nb_addr(addr_ff, FACE_POS_Z);
            mem_re   = (rd_data_ff != '0);
         end
         ST_FACE: begin
            mem_addr = nb_addr(addr_ff, face_ff + 3'd1);
            if (!pend_valid_ff) begin
               rsp_data.face         = face_ff;
               rsp_data.first_vertex = count_ff;
            end
            rsp_data.last = final_face && !(show && pend_valid_ff);
            if (!stall) begin
               rsp_push = push_need;
               if (show) begin
                  count_in = count_ff + VERTS_PER_FACE;
               end
               // hold a shown face back until the next one tells whether it is last
               if (show && (pend_valid_ff || !final_face)) begin
                  pend_valid_in = 1'b1;
                  pend_face_in  = face_ff;
                  pend_first_in = count_ff;
               end else if (push_need) begin
                  pend_valid_in = 1'b0;
               end
               if (!final_face) begin
                  face_in = face_ff + 3'd1;
                  mem_re  = 1'b1;
               end
            end
         end
         ST_FLUSH: begin
            if (!stall) begin
               rsp_push      = 1'b1;
               pend_valid_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         count_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      addr_ff       <= addr_in;
      value_ff      <= value_in;
      face_ff       <= face_in;
      pend_face_ff  <= pend_face_in;
      pend_first_ff <= pend_first_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= store_mem[mem_addr];
      end
   end

endmodule

FILE: src/vfcm_checker.sv
// ----------------------------------------------------------------------------
// vfcm_checker
// Port-level checks of the mesher, bound to the top level.
// ----------------------------------------------------------------------------
module vfcm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [2:0]  rsp_face,
   input logic [14:0] rsp_center_x,
   input logic [14:0] rsp_center_y,
   input logic [16:0] rsp_center_z,
   input logic [21:0] rsp_first_vertex,
   input logic        rsp_last
);
   import vfcm_pkg::*;

   // both queues come out of reset drained
   a_reset_drains: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not drained after reset");

   a_face_code: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_face <= FACE_NEG_X)
      else $error("face code out of range");

   // vertex indexes advance in steps of four
   a_vertex_align: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_first_vertex[1:0] == 2'b00)
      else $error("first vertex not aligned to a face");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_face)
         && $stable(rsp_center_x) && $stable(rsp_center_y) && $stable(rsp_center_z)
         && $stable(rsp_first_vertex) && $stable(rsp_last))
      else $error("stalled result changed");

endmodule

bind voxel_face_cull_mesher_top vfcm_checker u_checker (.*);
